// File: design/pcx_rle_blit_decoder_unit_assert.svh
// Assertion macros for the PCX run-length blit decoder checker.
// No dependencies; included by the checker file only.
`ifndef PCX_RLE_BLIT_DECODER_UNIT_ASSERT_SVH
`define PCX_RLE_BLIT_DECODER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, quiet while rst_ni is low.
`define PCXRLE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, quiet while rst_ni is low.
`define PCXRLE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/pcxrle_pkg.sv
// Shared types and constants of the PCX run-length blit decoder.
// No dependencies; imported by the top, front, back and checker modules.
`default_nettype none

package pcxrle_pkg;

  localparam int DEF_MAX_DIMENSION = 4096;

  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 3;
  localparam int ADDR_W     = 24;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEST_X        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DEST_Y        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BUFFER_WIDTH  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BUFFER_HEIGHT = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_TRANSPARENT   = 3'd6;

  localparam logic [7:0] RUN_MARK = 8'hBF;
  localparam logic [5:0] RUN_BITS = 6'h3F;

  localparam int CMD_Q_DEPTH = 2;
  localparam int OUT_Q_DEPTH = 4;

  typedef struct packed {
    logic [12:0] image_width;
    logic [12:0] image_height;
    logic [11:0] dest_x;
    logic [11:0] dest_y;
    logic [12:0] buffer_width;
    logic [12:0] buffer_height;
    logic        transparent;
  } cfg_t;

  // one decoded run: value repeated count times (count never zero)
  typedef struct packed {
    logic [7:0] value;
    logic [5:0] count;
  } cmd_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [7:0]        value;
    logic              we;
    logic              last;
    logic              done;
  } pix_t;

endpackage

`default_nettype wire

// File: design/pcx_rle_blit_decoder_unit.sv
// Top level of the PCX run-length blit decoder: registers, queues, front, back.
// Depends on pcxrle_pkg, pcxrle_fifo, pcxrle_front and pcxrle_back.
//
//  channel   direction  handshake              payload
//  --------  ---------  ---------------------  -----------------------------------
//  input     in         push / full            code_byte_i
//  result    out        empty / pop            pixel_address_o, pixel_value_o,
//                                              write_enable_o, last_of_run_o,
//                                              image_done_o
//  config    in         cfg_we_i (no wait)     cfg_index_i, cfg_data_i
//
// A coded byte is taken while the run queue has room; a run header yields
// no pixel, a value byte yields its whole run to the back end. The back end
// issues one pixel per cycle while the pixel queue has room (the run walker
// and the y*pitch multiplier); a pixel passes the multiply stage register
// and the pixel queue before the result ports. No clearing pass after reset:
// counters, queue pointers and the frame flag reset at once. Either side may
// stall on its own; the run queue and pixel queue absorb the difference.
`default_nettype none

module pcx_rle_blit_decoder_unit
  import pcxrle_pkg::*;
#(
  parameter int MAX_DIMENSION = DEF_MAX_DIMENSION
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // coded byte input
  input  logic                  push,
  output logic                  full,
  input  logic [7:0]            code_byte_i,
  // pixel output
  output logic                  empty,
  input  logic                  pop,
  output logic [ADDR_W-1:0]     pixel_address_o,
  output logic [7:0]            pixel_value_o,
  output logic                  write_enable_o,
  output logic                  last_of_run_o,
  output logic                  image_done_o,
  // register writes
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int OCW = $clog2(OUT_Q_DEPTH + 1);
  localparam int QCW = $clog2(CMD_Q_DEPTH + 1);

  cfg_t cfg_q;

  // front -> run queue
  logic  cmd_push, cmd_full, cmd_empty, cmd_pop;
  cmd_t  cmd_in, cmd_out;
  logic [QCW-1:0] cmd_count;

  // back -> pixel queue
  logic  pix_valid, out_empty;
  pix_t  pix_in, pix_out;
  logic [OCW-1:0] out_count;

  // Configuration registers. User must write only while idle; the block does not check.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.image_width   <= 13'd1;
      cfg_q.image_height  <= 13'd1;
      cfg_q.dest_x        <= '0;
      cfg_q.dest_y        <= '0;
      cfg_q.buffer_width  <= 13'd1;
      cfg_q.buffer_height <= 13'd1;
      cfg_q.transparent   <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_IMAGE_WIDTH:   cfg_q.image_width   <= cfg_data_i;
        CFG_IMAGE_HEIGHT:  cfg_q.image_height  <= cfg_data_i;
        CFG_DEST_X:        cfg_q.dest_x        <= cfg_data_i[11:0];
        CFG_DEST_Y:        cfg_q.dest_y        <= cfg_data_i[11:0];
        CFG_BUFFER_WIDTH:  cfg_q.buffer_width  <= cfg_data_i;
        CFG_BUFFER_HEIGHT: cfg_q.buffer_height <= cfg_data_i;
        CFG_TRANSPARENT:   cfg_q.transparent   <= cfg_data_i[0];
        default: ; // unmapped index: write dropped
      endcase
    end
  end

  // Front end: header/value pairing.
  pcxrle_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_push_i   (push),
    .code_byte_i (code_byte_i),
    .cmd_full_i  (cmd_full),
    .cmd_push_o  (cmd_push),
    .cmd_o       (cmd_in)
  );

  // Full whenever the run queue is, header beats included.
  assign full = cmd_full;

  // Run queue between front and back.
  pcxrle_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (CMD_Q_DEPTH)
  ) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .pop_i   (cmd_pop),
    .data_o  (cmd_out),
    .full_o  (cmd_full),
    .empty_o (cmd_empty),
    .count_o (cmd_count)
  );

  // Back end: run walker, position counters, address multiply.
  pcxrle_back #(
    .MAX_DIMENSION (MAX_DIMENSION)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_valid_i (!cmd_empty && (cmd_count != '0)),
    .cmd_i       (cmd_out),
    .cmd_pop_o   (cmd_pop),
    .out_count_i (out_count),
    .pix_valid_o (pix_valid),
    .pix_o       (pix_in)
  );

  // Pixel queue; the back end never pushes without room (credit on count).
  pcxrle_fifo #(
    .WIDTH ($bits(pix_t)),
    .DEPTH (OUT_Q_DEPTH)
  ) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (pix_valid),
    .data_i  (pix_in),
    .pop_i   (pop),
    .data_o  (pix_out),
    .full_o  (),
    .empty_o (out_empty),
    .count_o (out_count)
  );

  assign empty           = out_empty;
  assign pixel_address_o = pix_out.addr;
  assign pixel_value_o   = pix_out.value;
  assign write_enable_o  = pix_out.we;
  assign last_of_run_o   = pix_out.last;
  assign image_done_o    = pix_out.done;

endmodule

`default_nettype wire

// File: design/pcxrle_fifo.sv
// Small synchronous queue of register entries, used for runs and for pixels.
// Depends on nothing but its parameters.
`default_nettype none

module pcxrle_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic [WIDTH-1:0]           data_i,
  input  logic                       pop_i,
  output logic [WIDTH-1:0]           data_o,
  output logic                       full_o,
  output logic                       empty_o,
  output logic [$clog2(DEPTH+1)-1:0] count_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign count_o = count_q;
  assign data_o  = mem_q[rd_ptr_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

// File: design/pcxrle_front.sv
// Front end: takes coded bytes, pairs run headers with their value bytes.
// Depends on pcxrle_pkg (cmd_t, RUN_MARK, RUN_BITS).
`default_nettype none

module pcxrle_front
  import pcxrle_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_push_i,
  input  logic [7:0] code_byte_i,
  input  logic       cmd_full_i,
  output logic       cmd_push_o,
  output cmd_t       cmd_o
);

  logic       awaiting_q, awaiting_d;
  logic [5:0] pending_q, pending_d;
  logic       accept;

  assign accept = in_push_i && !cmd_full_i;

  always_comb begin
    awaiting_d  = awaiting_q;
    pending_d   = pending_q;
    cmd_push_o  = 1'b0;
    cmd_o.value = code_byte_i;
    cmd_o.count = 6'd1;
    if (accept) begin
      if (awaiting_q) begin
        awaiting_d  = 1'b0;
        cmd_o.count = pending_q;
        // zero-count run produces nothing
        cmd_push_o  = (pending_q != '0);
      end else if (code_byte_i > RUN_MARK) begin
        awaiting_d = 1'b1;
        pending_d  = code_byte_i[5:0] & RUN_BITS;
      end else begin
        cmd_push_o = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      awaiting_q <= 1'b0;
      pending_q  <= '0;
    end else begin
      awaiting_q <= awaiting_d;
      pending_q  <= pending_d;
    end
  end

endmodule

`default_nettype wire

// File: design/pcxrle_back.sv
// Back end: walks each run pixel by pixel, tracks column/row, forms addresses.
// Depends on pcxrle_pkg (cfg_t, cmd_t, pix_t, ADDR_W, OUT_Q_DEPTH).
`default_nettype none

module pcxrle_back
  import pcxrle_pkg::*;
#(
  parameter int MAX_DIMENSION = DEF_MAX_DIMENSION
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  cfg_t                           cfg_i,
  input  logic                           cmd_valid_i,
  input  cmd_t                           cmd_i,
  output logic                           cmd_pop_o,
  input  logic [$clog2(OUT_Q_DEPTH+1)-1:0] out_count_i,
  output logic                           pix_valid_o,
  output pix_t                           pix_o
);

  localparam int CW   = $clog2(MAX_DIMENSION);
  localparam int SW   = $clog2(MAX_DIMENSION + 1);
  localparam int EW   = SW + 1;
  localparam int XW   = ((CW > 12) ? CW : 12) + 1;
  localparam int CMPW = (SW > 13) ? SW : 13;
  localparam int BW   = (XW > SW) ? XW : SW;
  localparam int OCW  = $clog2(OUT_Q_DEPTH + 1);

  // size register of 0 acts as 1, above the maximum as the maximum
  function automatic logic [SW-1:0] clamp_size(input logic [12:0] v);
    logic [CMPW-1:0] ve;
    ve = CMPW'(v);
    if (ve == '0) begin
      clamp_size = SW'(1);
    end else if (ve > CMPW'(MAX_DIMENSION)) begin
      clamp_size = SW'(MAX_DIMENSION);
    end else begin
      clamp_size = SW'(ve);
    end
  endfunction

  logic [SW-1:0] w, h, bw, bh;

  logic          cur_valid_q, cur_valid_d;
  logic [7:0]    cur_value_q, cur_value_d;
  logic [5:0]    cur_left_q, cur_left_d;
  logic [CW-1:0] col_q, col_d, row_q, row_d;
  logic          frame_done_q, frame_done_d;

  logic [XW-1:0]     x, y;
  logic [EW-1:0]     col_inc, row_inc;
  logic              in_buf, we, row_end, done, last, issue, load;
  logic [ADDR_W-1:0] prod;

  logic              p1_valid_q;
  logic [ADDR_W-1:0] p1_prod_q;
  logic [XW-1:0]     p1_x_q;
  logic [7:0]        p1_value_q;
  logic              p1_we_q, p1_last_q, p1_done_q;

  assign w  = clamp_size(cfg_i.image_width);
  assign h  = clamp_size(cfg_i.image_height);
  assign bw = clamp_size(cfg_i.buffer_width);
  assign bh = clamp_size(cfg_i.buffer_height);

  assign x       = XW'(cfg_i.dest_x) + XW'(col_q);
  assign y       = XW'(cfg_i.dest_y) + XW'(row_q);
  assign col_inc = EW'(col_q) + EW'(1);
  assign row_inc = EW'(row_q) + EW'(1);
  assign row_end = (col_inc >= EW'(w));
  assign done    = row_end && (row_inc >= EW'(h));
  assign last    = done || (cur_left_q == 6'd1);
  assign in_buf  = (BW'(x) < BW'(bw)) && (BW'(y) < BW'(bh));
  assign we      = in_buf && !(cfg_i.transparent && (cur_value_q == '0));
  assign prod    = ADDR_W'(y) * ADDR_W'(bw);

  // room in the pixel queue counting the beat already in the multiply stage
  assign issue = cur_valid_q && !frame_done_q &&
                 ((OCW+1)'(out_count_i) + (OCW+1)'(p1_valid_q) < (OCW+1)'(OUT_Q_DEPTH));

  // after the final pixel, queued runs are drained and dropped
  assign cmd_pop_o = cmd_valid_i &&
                     (frame_done_q || !cur_valid_q || (issue && last));
  assign load      = cmd_pop_o && !frame_done_q && !(issue && done);

  always_comb begin
    cur_valid_d  = cur_valid_q;
    cur_value_d  = cur_value_q;
    cur_left_d   = cur_left_q;
    col_d        = col_q;
    row_d        = row_q;
    frame_done_d = frame_done_q;
    if (issue) begin
      cur_left_d = cur_left_q - 6'd1;
      if (done) begin
        frame_done_d = 1'b1;
        cur_valid_d  = 1'b0;
      end else begin
        if (row_end) begin
          col_d = '0;
          row_d = row_q + CW'(1);
        end else begin
          col_d = col_q + CW'(1);
        end
        if (cur_left_q == 6'd1) begin
          cur_valid_d = 1'b0;
        end
      end
    end
    if (load) begin
      cur_valid_d = 1'b1;
      cur_value_d = cmd_i.value;
      cur_left_d  = cmd_i.count;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q  <= 1'b0;
      cur_left_q   <= '0;
      col_q        <= '0;
      row_q        <= '0;
      frame_done_q <= 1'b0;
      p1_valid_q   <= 1'b0;
    end else begin
      cur_valid_q  <= cur_valid_d;
      cur_left_q   <= cur_left_d;
      col_q        <= col_d;
      row_q        <= row_d;
      frame_done_q <= frame_done_d;
      p1_valid_q   <= issue;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_value_q <= cur_value_d;
    if (issue) begin
      p1_prod_q  <= prod;
      p1_x_q     <= x;
      p1_value_q <= cur_value_q;
      p1_we_q    <= we;
      p1_last_q  <= last;
      p1_done_q  <= done;
    end
  end

  assign pix_valid_o = p1_valid_q;
  assign pix_o.addr  = p1_prod_q + ADDR_W'(p1_x_q);
  assign pix_o.value = p1_value_q;
  assign pix_o.we    = p1_we_q;
  assign pix_o.last  = p1_last_q;
  assign pix_o.done  = p1_done_q;

endmodule

`default_nettype wire

// File: design/pcxrle_checker.sv
// Port-level checker for the PCX run-length blit decoder, bound to its top.
// Depends on pcxrle_pkg and pcx_rle_blit_decoder_unit_assert.svh.
`default_nettype none

`include "pcx_rle_blit_decoder_unit_assert.svh"

module pcxrle_checker
  import pcxrle_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              empty,
  input  logic              pop,
  input  logic [ADDR_W-1:0] pixel_address_o,
  input  logic [7:0]        pixel_value_o,
  input  logic              last_of_run_o,
  input  logic              image_done_o
);

  // final pixel always closes its run
  `PCXRLE_ASSERT_NOW(a_done_is_last, !empty && image_done_o, last_of_run_o, "image_done without last_of_run")

  // nothing follows the final pixel until reset
  `PCXRLE_ASSERT_NEXT(a_quiet_after_done, pop && !empty && image_done_o, empty, "pixel after image end")

  // a waiting beat holds still
  `PCXRLE_ASSERT_NEXT(a_hold_addr, !empty && !pop, !empty && $stable(pixel_address_o) && $stable(pixel_value_o), "stalled pixel moved")

endmodule

bind pcx_rle_blit_decoder_unit pcxrle_checker u_pcxrle_checker (.*);

`default_nettype wire
